// ===== design/dsp_pkg.sv =====
// Package for the shortest-path block: field widths, input codes, state
// encoding and the packed item types of both channels.
// Depends on nothing; the top module and the checker import it.
package dsp_pkg;

    // Graph size and field widths.
    localparam int MAX_VERTICES  = 64;
    localparam int VERTEX_W      = 6;
    localparam int COUNT_W       = 7;
    localparam int WEIGHT_W      = 7;
    localparam int DIST_W        = 13;
    localparam int MODE_W        = 2;
    localparam int VERTEX_SLOTS  = 1 << VERTEX_W;
    localparam int ADJ_ADDR_W    = 2 * VERTEX_W;
    localparam int ADJ_DEPTH     = 1 << ADJ_ADDR_W;

    // Weight code that marks a missing edge.
    localparam logic [WEIGHT_W-1:0] NO_EDGE = '1;

    // Input item codes.
    localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE1,
        S_EDGE2,
        S_INIT,
        S_SCAN,
        S_RELAX,
        S_OUT_RD,
        S_OUT_LD
    } state_t;

    // One input item.
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [WEIGHT_W-1:0] weight;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [DIST_W-1:0]   distance;
        logic                reached;
        logic                last;
    } out_item_t;

endpackage

// ===== design/dsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; width and depth come from its parameters.
module dsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/dijkstra_shortest_paths_top.sv =====
// Shortest-path engine: after reset and after every clear item the adjacency
// memory is swept, one entry a cycle, with no item accepted. A run over n
// vertices visits up to n vertices; each visit costs a minimum scan and a row
// relaxation, each a pass over the n vertices, paced by the single read port of
// the distance memory and its registered read.
// Results leave through an output register; the next item is taken while the
// final result of a run still waits. Reset is synchronous and active low.
module dijkstra_shortest_paths_top
    import dsp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data
);

    state_t                  state_reg, state_next;
    logic [ADJ_ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [COUNT_W-1:0]      idx_reg, idx_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [VERTEX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                    found_reg, found_next;
    logic [VERTEX_W-1:0]     best_reg, best_next;
    logic [DIST_W-1:0]       best_dist_reg, best_dist_next;
    logic [VERTEX_W-1:0]     a_reg, a_next;
    logic [VERTEX_W-1:0]     b_reg, b_next;
    logic [WEIGHT_W-1:0]     w_reg, w_next;
    logic [VERTEX_SLOTS-1:0] reached_reg, reached_next;
    logic [VERTEX_SLOTS-1:0] visited_reg, visited_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;
    logic [COUNT_W-1:0]      vcount_reg;

    logic [COUNT_W-1:0]      n_use;
    logic                    issue;
    logic [DIST_W:0]         cand;

    logic                    adj_we;
    logic [ADJ_ADDR_W-1:0]   adj_waddr;
    logic [WEIGHT_W-1:0]     adj_wdata;
    logic [ADJ_ADDR_W-1:0]   adj_raddr;
    logic [WEIGHT_W-1:0]     adj_rdata;
    logic                    dist_we;
    logic [VERTEX_W-1:0]     dist_waddr;
    logic [DIST_W-1:0]       dist_wdata;
    logic [VERTEX_W-1:0]     dist_raddr;
    logic [DIST_W-1:0]       dist_rdata;

    // Adjacency matrix, addressed by row then column.
    dsp_ram #(.WIDTH(WEIGHT_W), .DEPTH(ADJ_DEPTH)) u_adj_ram (
        .aclk    (aclk),
        .wr_en   (adj_we),
        .wr_addr (adj_waddr),
        .wr_data (adj_wdata),
        .rd_addr (adj_raddr),
        .rd_data (adj_rdata)
    );

    // Tentative distance of each vertex.
    dsp_ram #(.WIDTH(DIST_W), .DEPTH(VERTEX_SLOTS)) u_dist_ram (
        .aclk    (aclk),
        .wr_en   (dist_we),
        .wr_addr (dist_waddr),
        .wr_data (dist_wdata),
        .rd_addr (dist_raddr),
        .rd_data (dist_rdata)
    );

    // Vertices in use, with out-of-range register values clamped.
    always_comb begin
        if (vcount_reg == '0) begin
            n_use = COUNT_W'(1);
        end else if (vcount_reg > COUNT_W'(MAX_VERTICES)) begin
            n_use = COUNT_W'(MAX_VERTICES);
        end else begin
            n_use = vcount_reg;
        end
    end

    assign issue   = idx_reg < n_use;
    assign cand    = {1'b0, best_dist_reg} + {{(DIST_W + 1 - WEIGHT_W){1'b0}}, adj_rdata};
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Next state, memory accesses and datapath updates.
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        idx_next       = idx_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_dist_next = best_dist_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        reached_next   = reached_reg;
        visited_next   = visited_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        adj_we     = 1'b0;
        adj_waddr  = clr_cnt_reg;
        adj_wdata  = NO_EDGE;
        adj_raddr  = {best_reg, idx_reg[VERTEX_W-1:0]};
        dist_we    = 1'b0;
        dist_waddr = rd_idx_reg;
        dist_wdata = cand[DIST_W-1:0];
        dist_raddr = idx_reg[VERTEX_W-1:0];

        // The output register empties when its item is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            // Sweep every matrix entry back to no edge.
            S_CLEAR: begin
                adj_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + ADJ_ADDR_W'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = S_IDLE;
                end
            end

            // Take an item and decide what it asks for.
            S_IDLE: begin
                if (s_valid) begin
                    a_next = s_data.vertex_a;
                    b_next = s_data.vertex_b;
                    w_next = s_data.weight;
                    unique case (s_data.mode)
                        MODE_EDGE: begin
                            if ({1'b0, s_data.vertex_a} < n_use &&
                                {1'b0, s_data.vertex_b} < n_use) begin
                                state_next = S_EDGE1;
                            end
                        end
                        MODE_RUN: begin
                            if ({1'b0, s_data.vertex_a} < n_use) begin
                                state_next = S_INIT;
                            end
                        end
                        MODE_CLEAR: begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Symmetric edge write, one matrix entry a cycle.
            S_EDGE1: begin
                adj_we     = 1'b1;
                adj_waddr  = {a_reg, b_reg};
                adj_wdata  = w_reg;
                state_next = S_EDGE2;
            end

            S_EDGE2: begin
                adj_we     = 1'b1;
                adj_waddr  = {b_reg, a_reg};
                adj_wdata  = w_reg;
                state_next = S_IDLE;
            end

            // Seed the source vertex and clear the flags.
            S_INIT: begin
                dist_we             = 1'b1;
                dist_waddr          = a_reg;
                dist_wdata          = '0;
                reached_next        = '0;
                reached_next[a_reg] = 1'b1;
                visited_next        = '0;
                idx_next            = '0;
                found_next          = 1'b0;
                state_next          = S_SCAN;
            end

            // Find the unvisited reached vertex of least distance; the
            // ascending order with a strict compare keeps the lowest index
            // on ties.
            S_SCAN: begin
                rd_vld_next = issue;
                rd_idx_next = idx_reg[VERTEX_W-1:0];
                if (issue) begin
                    idx_next = idx_reg + COUNT_W'(1);
                end
                if (rd_vld_reg && reached_reg[rd_idx_reg] && !visited_reg[rd_idx_reg] &&
                    (!found_reg || dist_rdata < best_dist_reg)) begin
                    found_next     = 1'b1;
                    best_next      = rd_idx_reg;
                    best_dist_next = dist_rdata;
                end
                if (!issue && !rd_vld_reg) begin
                    idx_next = '0;
                    if (found_reg) begin
                        visited_next[best_reg] = 1'b1;
                        state_next             = S_RELAX;
                    end else begin
                        state_next = S_OUT_RD;
                    end
                end
            end

            // Relax the row of the chosen vertex, one neighbour a cycle.
            S_RELAX: begin
                rd_vld_next = issue;
                rd_idx_next = idx_reg[VERTEX_W-1:0];
                if (issue) begin
                    idx_next = idx_reg + COUNT_W'(1);
                end
                if (rd_vld_reg && adj_rdata != NO_EDGE &&
                    (!reached_reg[rd_idx_reg] || cand < {1'b0, dist_rdata})) begin
                    dist_we                  = 1'b1;
                    reached_next[rd_idx_reg] = 1'b1;
                end
                if (!issue && !rd_vld_reg) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
            end

            // Read the next distance once the output register is free.
            S_OUT_RD: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_OUT_LD;
                end
            end

            // Load one result item.
            S_OUT_LD: begin
                m_valid_next         = 1'b1;
                m_data_next.vertex   = idx_reg[VERTEX_W-1:0];
                m_data_next.reached  = reached_reg[idx_reg[VERTEX_W-1:0]];
                m_data_next.distance = reached_reg[idx_reg[VERTEX_W-1:0]] ? dist_rdata : '0;
                m_data_next.last     = (idx_reg + COUNT_W'(1)) == n_use;
                if ((idx_reg + COUNT_W'(1)) == n_use) begin
                    state_next = S_IDLE;
                end else begin
                    idx_next   = idx_reg + COUNT_W'(1);
                    state_next = S_OUT_RD;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            reached_reg <= '0;
            visited_reg <= '0;
            m_valid_reg <= 1'b0;
            vcount_reg  <= COUNT_W'(MAX_VERTICES);
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            idx_reg     <= idx_next;
            rd_vld_reg  <= rd_vld_next;
            found_reg   <= found_next;
            reached_reg <= reached_next;
            visited_reg <= visited_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                vcount_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        best_reg      <= best_next;
        best_dist_reg <= best_dist_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        w_reg         <= w_next;
        m_data_reg    <= m_data_next;
    end

endmodule

// ===== design/dsp_checker.sv =====
// Port-level checks on the shortest-path block, attached by a bind below.
// Depends on dsp_pkg and on dijkstra_shortest_paths_top.
module dsp_checker
    import dsp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input out_item_t          m_data
);

    // A stalled result item holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // An unreached vertex reports distance zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.reached |-> m_data.distance == '0)
        else $error("unreached vertex with non-zero distance");

    // No item is taken while a run still has results to give.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !s_ready)
        else $error("item accepted in the middle of a run");

    // After reset the block clears its matrix and shows no result.
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block not quiet after reset");

endmodule

bind dijkstra_shortest_paths_top dsp_checker u_dsp_checker (.*);

// ===== tb/sv/dijkstra_shortest_paths_top_tb.sv =====
// Self-checking testbench for the shortest-path engine: edge writes, clears and
// searches go in, and each per-vertex result is checked against a predictor.
// Depends on dsp_pkg and dijkstra_shortest_paths_top.
`timescale 1ns / 100ps

module dijkstra_shortest_paths_top_tb;
    import dsp_pkg::*;

    // Input code that the block takes and ignores.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // Cycles allowed for a clear sweep to finish before the block counts as idle.
    localparam int SETTLE_CYCLES = 4200;
    // Number of effective random items to send.
    localparam int RANDOM_TARGET = 100;

    logic               aclk;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    in_item_t           s_data      = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    out_item_t          m_data;
    logic               cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;

    // Items waiting to be driven and per-vertex results still to arrive.
    in_item_t  pending_items[$];
    out_item_t path_results_due[$];

    bit calm;
    int items_queued;
    int items_driven;
    int items_taken;
    int random_items;
    int searches_seen;
    int results_checked;
    int mismatches;
    int count_writes;

    // Predictor copy of the graph, the search tables and the register.
    logic [WEIGHT_W-1:0] graph_w [MAX_VERTICES][MAX_VERTICES];
    logic [DIST_W-1:0]   path_dist [MAX_VERTICES];
    bit                  path_reached [MAX_VERTICES];
    bit                  path_done [MAX_VERTICES];
    logic [COUNT_W-1:0]  vertex_count_reg = COUNT_W'(MAX_VERTICES);

    dijkstra_shortest_paths_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 8 ns clock.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Number of vertices in use; out-of-range register values are clamped.
    function automatic int vertices_in_use();
        if (vertex_count_reg == 0) return 1;
        if (vertex_count_reg > MAX_VERTICES) return MAX_VERTICES;
        return int'(vertex_count_reg);
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < MAX_VERTICES; i++)
            for (int j = 0; j < MAX_VERTICES; j++)
                graph_w[i][j] = NO_EDGE;
    endfunction

    // Search by repeated minimum scan over unvisited reached vertices.
    function automatic void search_paths(int src, int n);
        int best;
        int cand;
        for (int v = 0; v < MAX_VERTICES; v++) begin
            path_reached[v] = 1'b0;
            path_done[v]    = 1'b0;
        end
        path_dist[src]    = '0;
        path_reached[src] = 1'b1;
        for (int step = 0; step < n; step++) begin
            best = n;
            for (int v = 0; v < n; v++)
                if (path_reached[v] && !path_done[v] &&
                    (best == n || path_dist[v] < path_dist[best]))
                    best = v;
            if (best == n) break;
            path_done[best] = 1'b1;
            for (int v = 0; v < n; v++) begin
                if (graph_w[best][v] == NO_EDGE) continue;
                cand = int'(path_dist[best]) + int'(graph_w[best][v]);
                if (!path_reached[v] || cand < int'(path_dist[v])) begin
                    path_dist[v]    = DIST_W'(cand);
                    path_reached[v] = 1'b1;
                end
            end
        end
    endfunction

    // Work out the effect of one accepted item and queue any results it causes.
    function automatic void predict_item(in_item_t it);
        int        n;
        int        a;
        int        b;
        out_item_t r;
        n = vertices_in_use();
        a = int'(it.vertex_a);
        b = int'(it.vertex_b);
        case (it.mode)
            MODE_EDGE: begin
                if (a < n && b < n) begin
                    graph_w[a][b] = it.weight;
                    graph_w[b][a] = it.weight;
                end
            end
            MODE_CLEAR: begin
                clear_graph();
            end
            MODE_RUN: begin
                if (a < n) begin
                    search_paths(a, n);
                    searches_seen++;
                    for (int v = 0; v < n; v++) begin
                        r.vertex   = VERTEX_W'(v);
                        r.distance = path_reached[v] ? path_dist[v] : '0;
                        r.reached  = path_reached[v];
                        r.last     = (v == n - 1);
                        path_results_due.push_back(r);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Sample both handshakes at the rising edge: predict on input, check on output.
    always @(posedge aclk) begin : observe
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_item(s_data);
                items_taken++;
            end
            if (m_valid && m_ready) begin
                if (path_results_due.size() == 0) begin
                    $error("result for vertex %0d with none expected", m_data.vertex);
                    mismatches++;
                end else begin
                    want = path_results_due.pop_front();
                    results_checked++;
                    if (m_data.vertex !== want.vertex) begin
                        $error("vertex: expected %0d, got %0d", want.vertex, m_data.vertex);
                        mismatches++;
                    end
                    if (m_data.distance !== want.distance) begin
                        $error("distance: expected %0d, got %0d",
                               want.distance, m_data.distance);
                        mismatches++;
                    end
                    if (m_data.reached !== want.reached) begin
                        $error("reached: expected %0d, got %0d",
                               want.reached, m_data.reached);
                        mismatches++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_data.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Drive at the falling edge: present the next item once the previous one is
    // taken, and stall the result channel at random.
    always @(negedge aclk) begin : drive
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || items_taken == items_driven) begin
                if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 11)) begin
                    s_data  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                    items_driven++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 11);
        end
    end

    task automatic queue_item(logic [MODE_W-1:0] mode, int a, int b, int w, bit counted);
        in_item_t it;
        it.mode     = mode;
        it.vertex_a = VERTEX_W'(a);
        it.vertex_b = VERTEX_W'(b);
        it.weight   = WEIGHT_W'(w);
        pending_items.push_back(it);
        items_queued++;
        if (counted) random_items++;
    endtask

    // Wait until everything sent is taken and answered, then let a clear finish.
    task automatic wait_idle();
        while (items_taken != items_queued || path_results_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_vertex_count(int value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COUNT_W'(value);
        vertex_count_reg = COUNT_W'(value);
        count_writes++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Weights lean towards the extremes and the no-edge code now and then.
    function automatic int pick_weight();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return 126;
        if (r == 2) return int'(NO_EDGE);
        return $urandom_range(0, 126);
    endfunction

    // A cleared graph with a path through vertices 0, 1, 2 and on, weighted from w_low up, searched from vertex 0.
    task automatic chain_sequence(int len, int w_low);
        queue_item(MODE_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 127), 1'b1);
        for (int i = 0; i + 1 < len; i++)
            queue_item(MODE_EDGE, i, i + 1, $urandom_range(w_low, 126), 1'b1);
        queue_item(MODE_RUN, 0, $urandom_range(0, 63), $urandom_range(0, 127), 1'b1);
    endtask

    // A few sequences at the current vertex count: mostly graph builds followed
    // by searches, with some edits, chains and items that must be ignored.
    task automatic random_phase(int n, bit long_chain);
        int kind;
        if (long_chain) chain_sequence((n < 40) ? n : 40, 120);
        repeat ($urandom_range(2, 4)) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                if ($urandom_range(0, 2) != 0)
                    queue_item(MODE_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 127), 1'b1);
                repeat ($urandom_range(1, (n < 12) ? 2 * n : 24))
                    queue_item(MODE_EDGE, $urandom_range(0, n - 1),
                               $urandom_range(0, n - 1), pick_weight(), 1'b1);
                repeat ($urandom_range(1, 2))
                    queue_item(MODE_RUN, $urandom_range(0, n - 1), $urandom_range(0, 63),
                               $urandom_range(0, 127), 1'b1);
            end else if (kind == 6 && n <= 16) begin
                chain_sequence(n, 0);
            end else if (kind <= 7) begin
                // Items that fall outside the graph in use, the unused code and noise.
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 3))
                        0: queue_item(MODE_UNUSED, $urandom_range(0, 63),
                                      $urandom_range(0, 63), $urandom_range(0, 127), 1'b0);
                        1: if (n < MAX_VERTICES)
                               queue_item(MODE_EDGE, $urandom_range(n, 63),
                                          $urandom_range(0, 63), pick_weight(), 1'b0);
                        2: if (n < MAX_VERTICES)
                               queue_item(MODE_RUN, $urandom_range(n, 63),
                                          $urandom_range(0, 63), $urandom_range(0, 127), 1'b0);
                        default: queue_item(MODE_W'($urandom_range(0, 3)),
                                            $urandom_range(0, 63), $urandom_range(0, 63),
                                            $urandom_range(0, 127), 1'b0);
                    endcase
                end
            end else begin
                // Edit the existing graph, deleting edges often, then search again.
                repeat ($urandom_range(1, 4))
                    queue_item(MODE_EDGE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                               ($urandom_range(0, 1) != 0) ? int'(NO_EDGE) : pick_weight(),
                               1'b1);
                queue_item(MODE_RUN, $urandom_range(0, n - 1), $urandom_range(0, 63),
                           $urandom_range(0, 127), 1'b1);
            end
        end
    endtask

    // Main sequence: reset, directed cases, then random phases over several counts.
    initial begin : stimulus
        int plan [10];
        int phase;
        plan = '{65, 8, 64, 2, 16, 33, 5, 24, 64, 12};
        clear_graph();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // All 64 vertices in use: empty graph, extreme weights, self loop,
        // no-edge write, unused code, edge deletion and a search after a clear.
        queue_item(MODE_RUN, 0, 0, 0, 1'b0);
        queue_item(MODE_EDGE, 0, 63, 126, 1'b0);
        queue_item(MODE_EDGE, 63, 42, 0, 1'b0);
        queue_item(MODE_EDGE, 21, 21, 0, 1'b0);
        queue_item(MODE_EDGE, 42, 21, 1, 1'b0);
        queue_item(MODE_EDGE, 10, 20, int'(NO_EDGE), 1'b0);
        queue_item(MODE_UNUSED, 63, 63, 127, 1'b0);
        queue_item(MODE_RUN, 63, 0, 0, 1'b0);
        queue_item(MODE_EDGE, 0, 63, int'(NO_EDGE), 1'b0);
        queue_item(MODE_RUN, 21, 63, 127, 1'b0);
        queue_item(MODE_CLEAR, 0, 0, 0, 1'b0);
        queue_item(MODE_RUN, 42, 0, 0, 1'b0);

        // One vertex: self loop, endpoint and source outside the graph.
        write_vertex_count(1);
        queue_item(MODE_EDGE, 0, 0, 5, 1'b0);
        queue_item(MODE_EDGE, 0, 1, 3, 1'b0);
        queue_item(MODE_RUN, 1, 0, 0, 1'b0);
        queue_item(MODE_RUN, 0, 0, 0, 1'b0);

        // Zero acts as one vertex.
        write_vertex_count(0);
        queue_item(MODE_RUN, 0, 0, 0, 1'b0);
        queue_item(MODE_EDGE, 1, 0, 9, 1'b0);

        // The top register value acts as all vertices.
        write_vertex_count(127);
        queue_item(MODE_EDGE, 62, 63, 126, 1'b0);
        queue_item(MODE_RUN, 62, 0, 0, 1'b0);
        queue_item(MODE_CLEAR, 63, 63, 127, 1'b0);

        // Random phases; one of them runs with no stalls on either side.
        phase = 0;
        while (random_items < RANDOM_TARGET) begin
            write_vertex_count(plan[phase % 10]);
            calm = (phase == 2);
            random_phase(vertices_in_use(), phase == 0);
            phase++;
        end
        wait_idle();

        $display("Run covered %0d items (%0d random), %0d searches and %0d checked results,",
                 items_taken, random_items, searches_seen, results_checked);
        $display("over %0d writes of the vertex count, with %0d mismatches.",
                 count_writes, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hard limit well beyond the slowest correct run.
    initial begin : watchdog
        #80_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
